[rtl/vtpl_pkg.sv]
// Package for the vertex transform / projection / lighting block.
// Field widths, register indexes, divider sizing and screen defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vtpl_pkg;
	// field widths
	localparam int COORD_W  = 16;
	localparam int COEF_W   = 11;
	localparam int ROW_W    = 3 * COEF_W;
	localparam int DEPTH_W  = 32;
	localparam int SHADE_W  = 8;
	localparam int IDX_W    = 3;

	// internal widths: |coord*coef| <= 2^25, sum of three plus pos*256 < 2^27
	localparam int PROD_W   = COORD_W + COEF_W;
	localparam int NPROD_W  = 2 * COEF_W;
	localparam int VIEW_W   = 29;
	localparam int NSUM_W   = NPROD_W + 2;
	localparam int MAG_W    = VIEW_W - 1;
	localparam int FRAC_W   = 8;
	localparam int NUM_W    = MAG_W + FRAC_W;

	// screen defaults
	localparam int SCREEN_WIDTH_DEF  = 960;
	localparam int SCREEN_HEIGHT_DEF = 544;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ROT_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROT_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROT_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_POS_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_POS_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_POS_Z = 3'd5;
	localparam logic [IDX_W-1:0] REG_LIGHT = 3'd6;

	// register reset values (identity matrix)
	localparam logic [ROW_W-1:0] ROT_X_RST = 33'd256;
	localparam logic [ROW_W-1:0] ROT_Y_RST = 33'd524288;
	localparam logic [ROW_W-1:0] ROT_Z_RST = 33'd1073741824;
endpackage
`default_nettype wire

[rtl/vtpl_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Carries a tag alongside each transaction. Standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none
module vtpl_div #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 28,
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [TAG_W-1:0] tag,
	output logic                  out_valid,
	output logic [NUM_W-1:0]      quo,
	output logic [TAG_W-1:0]      out_tag
);
	logic             vld_s [1:NUM_W];
	logic [DEN_W-1:0] rem_s [1:NUM_W];
	logic [NUM_W-1:0] num_s [1:NUM_W];
	logic [NUM_W-1:0] quo_s [1:NUM_W];
	logic [DEN_W-1:0] den_s [1:NUM_W];
	logic [TAG_W-1:0] tag_s [1:NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             vld_in;
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] num_in;
		logic [NUM_W-1:0] quo_in;
		logic [DEN_W-1:0] den_in;
		logic [TAG_W-1:0] tag_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign num_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign tag_in = tag;
		end else begin : g_next
			assign vld_in = vld_s[i];
			assign rem_in = rem_s[i];
			assign num_in = num_s[i];
			assign quo_in = quo_s[i];
			assign den_in = den_s[i];
			assign tag_in = tag_s[i];
		end

		// shift in the next numerator bit, subtract when it fits
		assign trial = {rem_in, num_in[NUM_W-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
			num_s[i+1] <= {num_in[NUM_W-2:0], 1'b0};
			quo_s[i+1] <= {quo_in[NUM_W-2:0], ge};
			den_s[i+1] <= den_in;
			tag_s[i+1] <= tag_in;
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = quo_s[NUM_W];
	assign out_tag   = tag_s[NUM_W];
endmodule
`default_nettype wire

[rtl/vertex_transform_project_light.sv]
// Top level: vertex rotate/translate, perspective projection and shading.
// Uses vtpl_pkg and two vtpl_div instances.
//
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------
// vertex in | start, busy             | vert_x/y/z, norm_x/y/z, last_point
// result    | done (one-cycle strobe) | screen_x/y, view_depth, visible, shade, last_out
// config    | wr_en, wr_index         | wr_data
//
// One vertex per clock; busy is always low. Registered stages in order: multiply,
// sum, sign split, 36 divider stages (one quotient bit each), output stage.
// Reset clears valid bits and restores the identity matrix, zero position
// and view light mode. Nothing stalls: the result strobe follows every
// accepted transaction through the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_project_light #(
	parameter int SCREEN_WIDTH  = vtpl_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = vtpl_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [15:0]            vert_x,
	input  wire logic signed [15:0]            vert_y,
	input  wire logic signed [15:0]            vert_z,
	input  wire logic signed [10:0]            norm_x,
	input  wire logic signed [10:0]            norm_y,
	input  wire logic signed [10:0]            norm_z,
	input  wire logic                          last_point,
	input  wire logic                          wr_en,
	input  wire logic [vtpl_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [vtpl_pkg::ROW_W-1:0]    wr_data,
	output logic                               done,
	output logic signed [15:0]                 screen_x,
	output logic signed [15:0]                 screen_y,
	output logic signed [31:0]                 view_depth,
	output logic                               visible,
	output logic [7:0]                         shade,
	output logic                               last_out
);
	localparam int PROD_W  = vtpl_pkg::PROD_W;
	localparam int NPROD_W = vtpl_pkg::NPROD_W;
	localparam int VIEW_W  = vtpl_pkg::VIEW_W;
	localparam int NSUM_W  = vtpl_pkg::NSUM_W;
	localparam int MAG_W   = vtpl_pkg::MAG_W;
	localparam int NUM_W   = vtpl_pkg::NUM_W;
	localparam int COEF_W  = vtpl_pkg::COEF_W;
	localparam int SC_W    = NUM_W + 2;
	localparam int HALF_X  = SCREEN_WIDTH / 2;
	localparam int HALF_Y  = SCREEN_HEIGHT / 2;
	localparam int TAG_W   = vtpl_pkg::DEPTH_W + vtpl_pkg::SHADE_W + 3;

	typedef logic signed [COEF_W-1:0] coef_t;

	// configuration registers
	logic [vtpl_pkg::ROW_W-1:0] rot_x_q, rot_y_q, rot_z_q;
	logic signed [15:0]         pos_x_q, pos_y_q, pos_z_q;
	logic                       light_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q <= vtpl_pkg::ROT_X_RST;
			rot_y_q <= vtpl_pkg::ROT_Y_RST;
			rot_z_q <= vtpl_pkg::ROT_Z_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			light_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				vtpl_pkg::REG_ROT_X: rot_x_q <= wr_data;
				vtpl_pkg::REG_ROT_Y: rot_y_q <= wr_data;
				vtpl_pkg::REG_ROT_Z: rot_z_q <= wr_data;
				vtpl_pkg::REG_POS_X: pos_x_q <= wr_data[15:0];
				vtpl_pkg::REG_POS_Y: pos_y_q <= wr_data[15:0];
				vtpl_pkg::REG_POS_Z: pos_z_q <= wr_data[15:0];
				vtpl_pkg::REG_LIGHT: light_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// matrix coefficients
	coef_t cx [3];
	coef_t cy [3];
	coef_t cz [3];
	for (genvar k = 0; k < 3; k++) begin : g_coef
		assign cx[k] = rot_x_q[COEF_W*k +: COEF_W];
		assign cy[k] = rot_y_q[COEF_W*k +: COEF_W];
		assign cz[k] = rot_z_q[COEF_W*k +: COEF_W];
	end

	// stage 1: products
	logic                      vld_s1, last_s1;
	logic signed [PROD_W-1:0]  px_s1 [3];
	logic signed [PROD_W-1:0]  py_s1 [3];
	logic signed [PROD_W-1:0]  pz_s1 [3];
	logic signed [NPROD_W-1:0] pn_s1 [3];
	logic signed [15:0]        vin [3];
	logic signed [10:0]        nin [3];

	assign vin[0] = vert_x;
	assign vin[1] = vert_y;
	assign vin[2] = vert_z;
	assign nin[0] = norm_x;
	assign nin[1] = norm_y;
	assign nin[2] = norm_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= last_point;
		for (int k = 0; k < 3; k++) begin
			px_s1[k] <= vin[k] * cx[k];
			py_s1[k] <= vin[k] * cy[k];
			pz_s1[k] <= vin[k] * cz[k];
			pn_s1[k] <= nin[k] * cz[k];
		end
	end

	// stage 2: dot products plus translation
	logic                      vld_s2, last_s2;
	logic signed [VIEW_W-1:0]  vx_s2, vy_s2, vz_s2;
	logic signed [NSUM_W-1:0]  nz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		vx_s2 <= VIEW_W'(px_s1[0]) + VIEW_W'(px_s1[1]) + VIEW_W'(px_s1[2])
			+ VIEW_W'($signed({pos_x_q, 8'b0}));
		vy_s2 <= VIEW_W'(py_s1[0]) + VIEW_W'(py_s1[1]) + VIEW_W'(py_s1[2])
			+ VIEW_W'($signed({pos_y_q, 8'b0}));
		vz_s2 <= VIEW_W'(pz_s1[0]) + VIEW_W'(pz_s1[1]) + VIEW_W'(pz_s1[2])
			+ VIEW_W'($signed({pos_z_q, 8'b0}));
		nz_s2 <= NSUM_W'(pn_s1[0]) + NSUM_W'(pn_s1[1]) + NSUM_W'(pn_s1[2]);
	end

	// stage 3: sign/magnitude split for the dividers, shade, depth
	logic                     vld_s3, last_s3, vis_s3, negx_s3, negy_s3;
	logic [NUM_W-1:0]         numx_s3, numy_s3;
	logic [MAG_W-1:0]         den_s3;
	logic [31:0]              depth_s3;
	logic [7:0]               shade_s3;
	logic [VIEW_W-1:0]        ax, ay;
	logic [7:0]               shade_c;

	assign ax = vx_s2[VIEW_W-1] ? VIEW_W'(-vx_s2) : VIEW_W'(vx_s2);
	assign ay = vy_s2[VIEW_W-1] ? VIEW_W'(-vy_s2) : VIEW_W'(vy_s2);

	// shade: nonpositive -> 0, moving light saturates, view light is z>>8 saturated to 255
	always_comb begin
		priority if (nz_s2 <= 0) begin
			shade_c = '0;
		end else if (light_q) begin
			shade_c = 8'hff;
		end else if (nz_s2[NSUM_W-1:16] != '0) begin
			shade_c = 8'hff;
		end else begin
			shade_c = nz_s2[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s3  <= last_s2;
		vis_s3   <= (vz_s2 > 0);
		negx_s3  <= vx_s2[VIEW_W-1];
		negy_s3  <= vy_s2[VIEW_W-1];
		numx_s3  <= {ax[MAG_W-1:0], 8'b0};
		numy_s3  <= {ay[MAG_W-1:0], 8'b0};
		den_s3   <= (vz_s2 > 0) ? vz_s2[MAG_W-1:0] : MAG_W'(1);
		depth_s3 <= 32'(vz_s2);
		shade_s3 <= shade_c;
	end

	// dividers
	logic             dvld_x, dvld_y;
	logic [NUM_W-1:0] qx, qy;
	logic [TAG_W-1:0] tag_x;
	logic             tag_y;

	vtpl_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .TAG_W(TAG_W)) u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.num       (numx_s3),
		.den       (den_s3),
		.tag       ({depth_s3, shade_s3, vis_s3, last_s3, negx_s3}),
		.out_valid (dvld_x),
		.quo       (qx),
		.out_tag   (tag_x)
	);

	vtpl_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .TAG_W(1)) u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.num       (numy_s3),
		.den       (den_s3),
		.tag       (negy_s3),
		.out_valid (dvld_y),
		.quo       (qy),
		.out_tag   (tag_y)
	);

	// output stage: restore sign, add screen center, saturate, zero when not visible
	logic signed [SC_W-1:0] sx_c, sy_c;
	logic signed [15:0]     satx, saty;
	logic                   vis_d;

	assign vis_d = tag_x[2];
	assign sx_c = (tag_x[0] ? -SC_W'(qx) : SC_W'(qx)) + SC_W'(HALF_X);
	assign sy_c = (tag_y    ? -SC_W'(qy) : SC_W'(qy)) + SC_W'(HALF_Y);

	always_comb begin
		priority if (sx_c > SC_W'(32767)) begin
			satx = 16'sh7fff;
		end else if (sx_c < -SC_W'(32768)) begin
			satx = 16'sh8000;
		end else begin
			satx = sx_c[15:0];
		end
		priority if (sy_c > SC_W'(32767)) begin
			saty = 16'sh7fff;
		end else if (sy_c < -SC_W'(32768)) begin
			saty = 16'sh8000;
		end else begin
			saty = sy_c[15:0];
		end
	end

	logic vld_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= dvld_x & dvld_y;
		end
	end

	logic signed [15:0] sx_s4, sy_s4;
	logic [31:0]        depth_s4;
	logic [7:0]         shade_s4;
	logic               vis_s4, last_s4;

	always_ff @(posedge clk) begin
		sx_s4    <= vis_d ? satx : '0;
		sy_s4    <= vis_d ? saty : '0;
		depth_s4 <= tag_x[TAG_W-1 -: 32];
		shade_s4 <= tag_x[10:3];
		vis_s4   <= vis_d;
		last_s4  <= tag_x[1];
	end

	assign done       = vld_s4;
	assign screen_x   = sx_s4;
	assign screen_y   = sy_s4;
	assign view_depth = depth_s4;
	assign visible    = vis_s4;
	assign shade      = shade_s4;
	assign last_out   = last_s4;
endmodule
`default_nettype wire

[tb/sv/vertex_transform_project_light_tb.sv]
// Testbench for vertex_transform_project_light: directed vertex table, then
// random vertices over several matrix, position and light settings, checked by a predictor.
// Depends on vtpl_pkg and the block's RTL.
`timescale 1ns / 1ps
module vertex_transform_project_light_tb;
	localparam logic [vtpl_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int LATENCY    = 40;
	localparam int STALL_MAX  = 5000;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int HALF_W = vtpl_pkg::SCREEN_WIDTH_DEF / 2;
	localparam int HALF_H = vtpl_pkg::SCREEN_HEIGHT_DEF / 2;
	localparam int ROW_W  = vtpl_pkg::ROW_W;
	localparam int IDX_W  = vtpl_pkg::IDX_W;

	typedef struct {
		logic signed [15:0] vx, vy, vz;
		logic signed [10:0] nx, ny, nz;
		logic               last;
	} vertex_t;

	typedef struct {
		logic signed [15:0] sx, sy;
		logic signed [31:0] depth;
		logic               vis;
		logic [7:0]         shade;
		logic               last;
	} pixel_t;

	typedef struct {
		vertex_t v;
		bit      typed;
		pixel_t  p;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] vert_x = '0, vert_y = '0, vert_z = '0;
	logic signed [10:0] norm_x = '0, norm_y = '0, norm_z = '0;
	logic last_point = 1'b0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [ROW_W-1:0] wr_data = '0;
	logic done;
	logic signed [15:0] screen_x, screen_y;
	logic signed [31:0] view_depth;
	logic visible;
	logic [7:0] shade;
	logic last_out;

	// model copy of the register file
	logic [ROW_W-1:0] m_row_x, m_row_y, m_row_z;
	longint m_pos_x, m_pos_y, m_pos_z;
	bit m_light;

	pixel_t pending_pixels[$];
	int errors = 0;
	int stall_cycles = 0;
	bit accepted;

	vertex_transform_project_light dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint row_dot(logic [ROW_W-1:0] row, longint a, longint b, longint c);
		longint k0, k1, k2;
		k0 = longint'($signed(row[10:0]));
		k1 = longint'($signed(row[21:11]));
		k2 = longint'($signed(row[32:22]));
		return a * k0 + b * k1 + c * k2;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rotate, translate, project and shade one vertex
	function automatic pixel_t project_vertex(vertex_t v);
		pixel_t p;
		longint wx, wy, wz, nzr, sh;
		wx = row_dot(m_row_x, v.vx, v.vy, v.vz) + m_pos_x * 256;
		wy = row_dot(m_row_y, v.vx, v.vy, v.vz) + m_pos_y * 256;
		wz = row_dot(m_row_z, v.vx, v.vy, v.vz) + m_pos_z * 256;
		nzr = row_dot(m_row_z, v.nx, v.ny, v.nz);
		p.vis = wz > 0;
		p.sx = '0;
		p.sy = '0;
		if (p.vis) begin
			p.sx = 16'(clamp((wx * 256) / wz + HALF_W, -32768, 32767));
			p.sy = 16'(clamp((wy * 256) / wz + HALF_H, -32768, 32767));
		end
		if (nzr <= 0)
			sh = 0;
		else if (m_light)
			sh = clamp(nzr * 256, 0, 255);
		else
			sh = clamp(nzr / 256, 0, 255);
		p.shade = sh[7:0];
		p.depth = 32'(clamp(wz, -64'sd2147483648, 64'sd2147483647));
		p.last = v.last;
		return p;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			vtpl_pkg::REG_ROT_X: m_row_x = data;
			vtpl_pkg::REG_ROT_Y: m_row_y = data;
			vtpl_pkg::REG_ROT_Z: m_row_z = data;
			vtpl_pkg::REG_POS_X: m_pos_x = longint'($signed(data[15:0]));
			vtpl_pkg::REG_POS_Y: m_pos_y = longint'($signed(data[15:0]));
			vtpl_pkg::REG_POS_Z: m_pos_z = longint'($signed(data[15:0]));
			vtpl_pkg::REG_LIGHT: m_light = data[0];
			default: ;
		endcase
	endtask

	// drive one transaction and hold until it is taken
	task automatic send_vertex(vertex_t v, bit typed, pixel_t p);
		start <= 1'b1;
		vert_x <= v.vx; vert_y <= v.vy; vert_z <= v.vz;
		norm_x <= v.nx; norm_y <= v.ny; norm_z <= v.nz;
		last_point <= v.last;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(typed ? p : project_vertex(v));
	endtask

	task automatic gap_after(int burst_left);
		int n;
		if (burst_left == 0 && $urandom_range(0, 3) != 0) begin
			n = $urandom_range(1, 12);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [ROW_W-1:0] rand_row(int kind);
		logic [ROW_W-1:0] r;
		case (kind)
			0: r = ROW_W'({$urandom, $urandom});
			1: r = {3{11'h3ff}};
			2: r = {3{11'h400}};
			3: r = {3{11'h7ff}};
			default: r = {11'($urandom_range(0, 300) - 150), 11'($urandom_range(0, 300) - 150),
				11'($urandom_range(0, 300) - 150)};
		endcase
		return r;
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		if ($urandom_range(0, 2) == 0) begin
			v.vx = 16'($urandom); v.vy = 16'($urandom); v.vz = 16'($urandom);
		end else begin
			v.vx = 16'($urandom_range(0, 2000) - 1000);
			v.vy = 16'($urandom_range(0, 2000) - 1000);
			v.vz = 16'($urandom_range(1, 4000));
		end
		v.nx = 11'($urandom); v.ny = 11'($urandom); v.nz = 11'($urandom);
		v.last = $urandom_range(0, 7) == 0;
		return v;
	endfunction

	// result checker
	always @(posedge clk) begin
		pixel_t e;
		if (done) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result sx=%0d sy=%0d", $time, screen_x, screen_y);
				errors++;
			end else begin
				e = pending_pixels.pop_front();
				if (screen_x !== e.sx) begin
					$display("%0t: screen_x exp %0d got %0d", $time, e.sx, screen_x); errors++;
				end
				if (screen_y !== e.sy) begin
					$display("%0t: screen_y exp %0d got %0d", $time, e.sy, screen_y); errors++;
				end
				if (view_depth !== e.depth) begin
					$display("%0t: view_depth exp %0d got %0d", $time, e.depth, view_depth);
					errors++;
				end
				if (visible !== e.vis) begin
					$display("%0t: visible exp %0b got %0b", $time, e.vis, visible); errors++;
				end
				if (shade !== e.shade) begin
					$display("%0t: shade exp %0d got %0d", $time, e.shade, shade); errors++;
				end
				if (last_out !== e.last) begin
					$display("%0t: last_out exp %0b got %0b", $time, e.last, last_out); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction either way
	always @(posedge clk) begin
		accepted = (start && !busy) || done || wr_en;
		stall_cycles = accepted ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		vec_row_t dir_rows[$];
		vec_row_t r;
		pixel_t none;
		int burst;
		m_row_x = vtpl_pkg::ROT_X_RST;
		m_row_y = vtpl_pkg::ROT_Y_RST;
		m_row_z = vtpl_pkg::ROT_Z_RST;
		m_pos_x = 0; m_pos_y = 0; m_pos_z = 0; m_light = 1'b0;
		none = '{sx: 0, sy: 0, depth: 0, vis: 0, shade: 0, last: 0};

		// directed vertices against the reset identity matrix
		r.typed = 1;
		r.v = '{0, 0, 0, 0, 0, 0, 0};  r.p = none;                    dir_rows.push_back(r);
		r.v = '{0, 0, 1, 0, 0, 1023, 1};
		r.p = '{sx: 480, sy: 272, depth: 256, vis: 1, shade: 255, last: 1}; dir_rows.push_back(r);
		r.v = '{32767, 32767, 1, 0, 0, -1024, 0};
		r.p = '{sx: 32767, sy: 32767, depth: 256, vis: 1, shade: 0, last: 0}; dir_rows.push_back(r);
		r.v = '{-32768, -32768, 1, 1023, 1023, 0, 0};
		r.p = '{sx: -32768, sy: -32768, depth: 256, vis: 1, shade: 0, last: 0};
		dir_rows.push_back(r);
		r.v = '{0, 0, -32768, 0, 0, 0, 1};  r.p = none; r.p.depth = -8388608; r.p.last = 1;
		dir_rows.push_back(r);
		r.typed = 0;
		r.v = '{100, -100, 32767, -1024, 1023, 512, 0}; dir_rows.push_back(r);
		r.v = '{-7, 9, 3, 0, 0, 300, 0};                dir_rows.push_back(r);
		r.v = '{32767, -32768, 32767, 0, 0, 256, 1};     dir_rows.push_back(r);
		r.v = '{5, 5, -1, 1023, -1024, 1023, 0};         dir_rows.push_back(r);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].p);
			gap_after($urandom_range(0, 1));
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// drain before touching the registers
			start <= 1'b0;
			wait (pending_pixels.size() == 0);
			repeat (LATENCY + 5) @(posedge clk);
			write_reg(vtpl_pkg::REG_ROT_X,
				ph == 0 ? vtpl_pkg::ROT_X_RST : rand_row($urandom_range(0, 4)));
			write_reg(vtpl_pkg::REG_ROT_Y,
				ph == 0 ? vtpl_pkg::ROT_Y_RST : rand_row($urandom_range(0, 4)));
			write_reg(vtpl_pkg::REG_ROT_Z, ph == 1 ? rand_row(1) : ph == 2 ? rand_row(2)
				: ph == 3 ? rand_row(3) : rand_row(ph == 0 ? 4 : $urandom_range(0, 4)));
			write_reg(vtpl_pkg::REG_POS_X,
				ph == 1 ? 33'h7fff : ph == 2 ? 33'h8000 : 33'($urandom));
			write_reg(vtpl_pkg::REG_POS_Y,
				ph == 1 ? 33'h7fff : ph == 2 ? 33'h8000 : 33'($urandom));
			write_reg(vtpl_pkg::REG_POS_Z, ph == 1 ? 33'h7fff : ph == 2 ? 33'h8000
				: 33'($urandom_range(0, 40)));
			write_reg(vtpl_pkg::REG_LIGHT, 33'(ph % 2));
			write_reg(REG_UNUSED, ROW_W'({$urandom, $urandom}));
			wr_en <= 1'b0;

			burst = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (burst == 0) burst = $urandom_range(1, 30);
				send_vertex(rand_vertex(), 0, none);
				burst--;
				gap_after(ph == 0 ? 1 : burst);
			end
		end
		start <= 1'b0;

		wait (pending_pixels.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
